### rtl/core/cartridge_bank_controller_macros.svh
// assertion macros for the cartridge bank controller
// no dependencies; taken in by the rtl files that carry assertions
`ifndef CARTRIDGE_BANK_CONTROLLER_MACROS_SVH
`define CARTRIDGE_BANK_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define CBC_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cbc check failed: %m");
// clocked check that also holds during reset
`define CBC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("cbc check failed: %m");
`else
`define CBC_ASSERT(name, clk, rstn, prop)
`define CBC_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

### rtl/core/cbc_pkg.sv
// shared types and constants for the cartridge bank controller
// no dependencies
`default_nettype none

package cbc_pkg;

  localparam int BANK_BYTES = 8192;
  localparam int OFFSET_W   = 13;

  // bus access kinds
  typedef enum logic [1:0] {
    FUNC_REG_WR = 2'd0,
    FUNC_RAM_WR = 2'd1,
    FUNC_RAM_RD = 2'd2
  } func_t;

  // register regions, address bits 14:13 below 0x8000
  typedef enum logic [1:0] {
    REGION_RAM_ENABLE = 2'd0,
    REGION_ROM_BANK   = 2'd1,
    REGION_RAM_BANK   = 2'd2,
    REGION_BANK_MODE  = 2'd3
  } region_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAPPER_MODE = 2'd0,
    CFG_ROM_COUNT   = 2'd1,
    CFG_RAM_COUNT   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
  localparam logic [7:0] READ_DISABLED  = 8'hFF;

  // word in flight between the ram access stage and the output register
  typedef struct packed {
    logic       rd_from_ram;
    logic [7:0] rd_fixed;
    logic [6:0] rom_bank;
    logic [1:0] ram_bank;
    logic       ram_on;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/cbc_ram.sv
// generic single-port synchronous ram, registered read
// no dependencies
`default_nettype none

module cbc_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/cartridge_bank_controller.sv
// cartridge bank controller, top level; uses cbc_pkg, cbc_ram and the macro header
// an accepted word passes stage 1 and the output register; one word per cycle
// unless out_ready stalls them; the single ram port takes one access per word
// reset (rst_n low, synchronous) restores registers and banks, then a clearing
// pass writes zero to all RAM_BANK_CNT*8192 ram bytes, one per cycle; no input
// word is taken during that pass, configuration writes are taken throughout
`default_nettype none
`include "cartridge_bank_controller_macros.svh"

module cartridge_bank_controller #(
  parameter int RAM_BANK_CNT = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // configuration write port
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  // input words
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_func,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0] in_data,
  // result words
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_read_data,
  output logic [6:0]      out_rom_bank,
  output logic [1:0]      out_ram_bank,
  output logic            out_ram_on
);

  localparam int RAM_DEPTH  = RAM_BANK_CNT * cbc_pkg::BANK_BYTES;
  localparam int RAM_ADDR_W = $clog2(RAM_DEPTH);

  // configuration registers
  logic       cfg_mode_r;
  logic [7:0] cfg_rom_count_r;
  logic [2:0] cfg_ram_count_r;

  // bank controller state
  logic [6:0] rom_bank_r, rom_bank_nxt;
  logic [1:0] ram_bank_r, ram_bank_nxt;
  logic       ram_en_r, ram_en_nxt;
  logic       bank_mode_r, bank_mode_nxt;

  cbc_pkg::state_t state_r, state_nxt;
  logic [RAM_ADDR_W-1:0] clr_addr_r;

  // pipeline: stage 1 waits on the ram read, then the output register
  logic             s1_v_r;
  cbc_pkg::result_t s1_r, s1_nxt;
  logic             out_v_r;
  logic [7:0]       out_rd_r;
  logic [6:0]       out_rom_r;
  logic [1:0]       out_ram_r;
  logic             out_on_r;

  logic accept, s1_move;
  logic [6:0] rom_mask, rom_sel;
  logic [1:0] ram_mask;
  logic [3:0] bank_mod;
  logic [RAM_ADDR_W-1:0] acc_addr, ram_addr;
  logic ram_we, ram_re;
  logic [7:0] ram_wdata, ram_rdata;

  function automatic logic [6:0] rom_bank_mask(input logic [7:0] cnt);
    rom_bank_mask = 7'(cnt - 8'd1);
  endfunction

  // handshake: stage 1 frees when empty or when it moves into the output register
  assign s1_move  = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = (state_r == cbc_pkg::ST_RUN) && (!s1_v_r || !out_v_r || out_ready);
  assign accept   = in_valid && in_ready;

  // stored banks are masked with count minus one, cut to register width
  assign rom_mask = rom_bank_mask(cfg_rom_count_r);
  assign ram_mask = 2'(cfg_ram_count_r - 3'd1);

  // register write decode
  always_comb begin
    rom_bank_nxt  = rom_bank_r;
    ram_bank_nxt  = ram_bank_r;
    ram_en_nxt    = ram_en_r;
    bank_mode_nxt = bank_mode_r;
    rom_sel       = 7'd0;
    if (accept && (in_func == cbc_pkg::FUNC_REG_WR) && !in_address[15]) begin
      unique case (in_address[14:13])
        cbc_pkg::REGION_RAM_ENABLE: begin
          ram_en_nxt = (in_data[3:0] == cbc_pkg::RAM_ENABLE_KEY);
        end
        cbc_pkg::REGION_ROM_BANK: begin
          if (cfg_mode_r) begin
            // mbc3: seven bits, bank zero reads as bank one
            rom_sel = in_data[6:0];
            if (in_data[6:0] == 7'd0) begin
              rom_sel = 7'd1;
            end
          end else begin
            // mbc1: low five bits; a zero low field steps up one bank
            rom_sel = {rom_bank_r[6:5], in_data[4:0]};
            if (in_data[4:0] == 5'd0) begin
              rom_sel[0] = 1'b1;
            end
          end
          rom_bank_nxt = rom_sel & rom_mask;
        end
        cbc_pkg::REGION_RAM_BANK: begin
          if (cfg_mode_r || bank_mode_r) begin
            ram_bank_nxt = in_data[1:0] & ram_mask;
          end else begin
            // mbc1 rom mode: upper rom bank bits, no zero fix-up
            rom_bank_nxt = {in_data[1:0], rom_bank_r[4:0]} & rom_mask;
          end
        end
        cbc_pkg::REGION_BANK_MODE: begin
          // mbc3 clock latch is not modeled, so only mbc1 reacts here
          if (!cfg_mode_r) begin
            bank_mode_nxt = in_data[0];
            if (in_data[0]) begin
              rom_bank_nxt = {2'b00, rom_bank_r[4:0]} & rom_mask;
            end else begin
              ram_bank_nxt = 2'd0;
            end
          end
        end
        default: begin
          rom_bank_nxt = rom_bank_r;
        end
      endcase
    end
  end

  // ram bank index wraps modulo RAM_BANK_CNT; the bank is at most 3 so three
  // compare-and-subtract steps always land below RAM_BANK_CNT
  always_comb begin
    bank_mod = {2'b00, ram_bank_r};
    for (int i = 0; i < 3; i++) begin
      if (bank_mod >= 4'(RAM_BANK_CNT)) begin
        bank_mod = bank_mod - 4'(RAM_BANK_CNT);
      end
    end
  end

  // offset is (address - 0xa000) & 0x1fff, which is just the low 13 bits
  assign acc_addr = RAM_ADDR_W'({bank_mod, in_address[cbc_pkg::OFFSET_W-1:0]});

  // ram port: clearing pass owns it after reset, then at most one access per word.
  // a write lands at the edge, so a read of that byte in the next cycle sees it
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = acc_addr;
    ram_wdata = in_data;
    if (state_r == cbc_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_addr_r;
      ram_wdata = 8'd0;
    end else if (accept && ram_en_r) begin
      ram_we = (in_func == cbc_pkg::FUNC_RAM_WR);
      ram_re = (in_func == cbc_pkg::FUNC_RAM_RD);
    end
  end

  cbc_ram #(
    .DATA_W (8),
    .DEPTH  (RAM_DEPTH)
  ) u_cart_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // stage 1 word: the fields after this item, and where the read byte comes from
  always_comb begin
    s1_nxt.rd_from_ram = ram_re;
    s1_nxt.rd_fixed    = 8'd0;
    if ((in_func == cbc_pkg::FUNC_RAM_RD) && !ram_en_r) begin
      s1_nxt.rd_fixed = cbc_pkg::READ_DISABLED;
    end
    s1_nxt.rom_bank = rom_bank_nxt;
    s1_nxt.ram_bank = ram_bank_nxt;
    s1_nxt.ram_on   = ram_en_nxt;
  end

  // clearing pass sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cbc_pkg::ST_CLEAR: begin
        if (clr_addr_r == RAM_ADDR_W'(RAM_DEPTH - 1)) begin
          state_nxt = cbc_pkg::ST_RUN;
        end
      end
      cbc_pkg::ST_RUN: begin
        state_nxt = cbc_pkg::ST_RUN;
      end
      default: begin
        state_nxt = cbc_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r      <= 1'b0;
      cfg_rom_count_r <= 8'd2;
      cfg_ram_count_r <= 3'd1;
      rom_bank_r      <= 7'd1;
      ram_bank_r      <= 2'd0;
      ram_en_r        <= 1'b0;
      bank_mode_r     <= 1'b0;
      state_r         <= cbc_pkg::ST_CLEAR;
      clr_addr_r      <= '0;
      s1_v_r          <= 1'b0;
      out_v_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cbc_pkg::CFG_MAPPER_MODE: cfg_mode_r      <= cfg_data[0];
          cbc_pkg::CFG_ROM_COUNT:   cfg_rom_count_r <= cfg_data;
          cbc_pkg::CFG_RAM_COUNT:   cfg_ram_count_r <= cfg_data[2:0];
          default: begin
            cfg_mode_r <= cfg_mode_r;
          end
        endcase
      end
      rom_bank_r  <= rom_bank_nxt;
      ram_bank_r  <= ram_bank_nxt;
      ram_en_r    <= ram_en_nxt;
      bank_mode_r <= bank_mode_nxt;
      state_r     <= state_nxt;
      if (state_r == cbc_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + RAM_ADDR_W'(1);
      end
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (s1_move) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    if (s1_move) begin
      out_rd_r  <= s1_r.rd_from_ram ? ram_rdata : s1_r.rd_fixed;
      out_rom_r <= s1_r.rom_bank;
      out_ram_r <= s1_r.ram_bank;
      out_on_r  <= s1_r.ram_on;
    end
  end

  assign out_valid     = out_v_r;
  assign out_read_data = out_rd_r;
  assign out_rom_bank  = out_rom_r;
  assign out_ram_bank  = out_ram_r;
  assign out_ram_on    = out_on_r;

  // a stalled stage 1 holds the ram read data, so no new read may start
  `CBC_ASSERT(a_no_read_while_held, clk, rst_n, (s1_v_r && out_v_r && !out_ready) |-> !ram_re)
  // the clearing pass only runs on an empty pipeline
  `CBC_ASSERT(a_clear_pipe_empty, clk, rst_n, (state_r == cbc_pkg::ST_CLEAR) |-> (!s1_v_r && !out_v_r))
  // one ram access per cycle
  `CBC_ASSERT_ALWAYS(a_single_access, clk, !(ram_we && ram_re))
  // once running, the clearing pass never restarts without reset
  `CBC_ASSERT(a_stay_running, clk, rst_n, (state_r == cbc_pkg::ST_RUN) |=> (state_r == cbc_pkg::ST_RUN))

endmodule

`default_nettype wire
